FILE: hdl/epitrochoid_point_generator_macros.svh
// Assertion macros used by the port checker
`ifndef EPITROCHOID_POINT_GENERATOR_MACROS_SVH
`define EPITROCHOID_POINT_GENERATOR_MACROS_SVH
// Implication checked every clock, disabled in reset
`define EPG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled in reset
`define EPG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: hdl/epg_pkg.sv
// ---------------------------------------------------------------------------
// epg_pkg
// Shared types and constants of the epitrochoid point generator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package epg_pkg;
  localparam int unsigned AccBits   = 48;
  localparam int unsigned RadBits   = 17;
  localparam int unsigned SpdBits   = 24;
  localparam int unsigned AtanCount = 30;
  localparam logic [31:0] GainQ32   = 32'h9B74EDA8;
  // CORDIC datapath width: radius(18) * gain >> 20 fits 31 bits, plus growth
  localparam int unsigned CordW     = 36;

  localparam logic [1:0] RegFixed   = 2'd0;
  localparam logic [1:0] RegRolling = 2'd1;
  localparam logic [1:0] RegPen     = 2'd2;
  localparam logic [1:0] RegSpeed   = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_EXTRA, ST_CEN_INIT, ST_CEN_RUN, ST_PEN_INIT, ST_PEN_RUN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } cord_ctl_t;

  function automatic logic [31:0] atan_turns(input logic [4:0] i);
    logic [31:0] r;
    begin
      unique case (i)
        5'd0: r = 32'h20000000; 5'd1: r = 32'h12E4051E; 5'd2: r = 32'h09FB385B;
        5'd3: r = 32'h051111D4; 5'd4: r = 32'h028B0D43; 5'd5: r = 32'h0145D7E1;
        5'd6: r = 32'h00A2F61E; 5'd7: r = 32'h00517C55; 5'd8: r = 32'h0028BE53;
        5'd9: r = 32'h00145F2F; 5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
        5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3; 5'd14: r = 32'h0000A2FA;
        5'd15: r = 32'h0000517D; 5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
        5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518; 5'd20: r = 32'h0000028C;
        5'd21: r = 32'h00000146; 5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
        5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014; 5'd26: r = 32'h0000000A;
        5'd27: r = 32'h00000005; 5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
        default: r = 32'h0;
      endcase
      return r;
    end
  endfunction
endpackage

FILE: hdl/epg_divider.sv
// ---------------------------------------------------------------------------
// epg_divider
// Restoring divider, one quotient bit per cycle, for angle / rolling radius.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module epg_divider #(
  parameter int unsigned NumW = 48,
  parameter int unsigned DenW = 17
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o,
  output logic [DenW-1:0] rem_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DenW:0]   trial;

  // Shift in one numerator bit and try to subtract
  always_comb begin
    trial  = {rem_q[DenW-1:0], quo_q[NumW-1]};
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q[DenW-1:0];
endmodule

FILE: hdl/epg_cordic.sv
// ---------------------------------------------------------------------------
// epg_cordic
// Iterative rotation CORDIC: radius * (cos, sin)(phase), rounded to 1/1024.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module epg_cordic #(
  parameter int unsigned Steps    = 20,
  parameter int unsigned FracBits = 24
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  epg_pkg::cord_ctl_t       ctl_i,
  input  logic [FracBits-1:0]      phase_i,
  input  logic [epg_pkg::RadBits:0] radius_i,
  output logic                     done_o,
  output logic signed [20:0]       x_o,
  output logic signed [20:0]       y_o
);
  localparam int unsigned W = epg_pkg::CordW;
  localparam int unsigned StepN = (Steps < epg_pkg::AtanCount) ? Steps : epg_pkg::AtanCount;

  logic signed [W-1:0]  x_q, y_q, x_d, y_d;
  logic signed [33:0]   z_q, z_d;
  logic [4:0]           i_q, i_d;
  logic [1:0]           q_q, q_d;
  logic                 done_q, done_d;
  logic [FracBits-1:0]  quarter_sum, resid;
  logic [1:0]           quad;
  logic [49:0]          prod;
  logic signed [W-1:0]  dx, dy, rx, ry;
  logic signed [33:0]   at;

  // Range reduction and gain-scaled start value
  always_comb begin
    quarter_sum = phase_i + (FracBits'(1) << (FracBits - 3));
    quad        = quarter_sum[FracBits-1 -: 2];
    resid       = phase_i - ({quad, {(FracBits-2){1'b0}}});
    prod        = 50'(radius_i) * 50'(epg_pkg::GainQ32);
  end

  // One micro-rotation per cycle
  always_comb begin
    dx = y_q >>> i_q;
    dy = x_q >>> i_q;
    at = 34'(epg_pkg::atan_turns(i_q));
    x_d = x_q; y_d = y_q; z_d = z_q; i_d = i_q; q_d = q_q; done_d = 1'b0;
    if (ctl_i.start) begin
      x_d = W'(prod >> 20);
      y_d = '0;
      z_d = 34'($signed(resid)) <<< (32 - FracBits);
      i_d = '0;
      q_d = quad;
    end else if (ctl_i.busy) begin
      if (!z_q[33]) begin
        x_d = x_q - dx; y_d = y_q + dy; z_d = z_q - at;
      end else begin
        x_d = x_q + dx; y_d = y_q - dy; z_d = z_q + at;
      end
      i_d = i_q + 1'b1;
      if (i_q == 5'(StepN - 1)) done_d = 1'b1;
    end
  end

  // Quarter-turn rotation and half-up rounding
  always_comb begin
    unique case (q_q)
      2'd1:    begin rx = -y_q; ry = x_q;  end
      2'd2:    begin rx = -x_q; ry = -y_q; end
      2'd3:    begin rx = y_q;  ry = -x_q; end
      default: begin rx = x_q;  ry = y_q;  end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= done_d;
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d; i_q <= i_d; q_q <= q_d;
  end

  logic signed [W-1:0] xr, yr;
  assign xr     = (rx + W'(2048)) >>> 12;
  assign yr     = (ry + W'(2048)) >>> 12;
  assign x_o    = xr[20:0];
  assign y_o    = yr[20:0];
  assign done_o = done_q;
endmodule

FILE: hdl/epitrochoid_point_generator.sv
// ---------------------------------------------------------------------------
// epitrochoid_point_generator
// Usage:
//  - s_axis: one word per tick, tdata[0] = advance (1 adds speed to angle).
//  - m_axis: one result word per tick, tdata from bit 0: centre_x[18:0],
//    centre_y[18:0], pen_x[19:0], pen_y[19:0] (80 bits).
//  - APB: fixed_radius 0x0, rolling_radius 0x4, pen_radius 0x8, speed 0xC.
// After acceptance the sequencer runs two divider passes (angle / rolling
// radius, then the remainder term), then the centre and pen CORDIC passes
// and an output state before m_axis_tvalid rises; the divider passes are
// skipped when rolling_radius is zero.
// One word at a time: s_axis_tready is low from acceptance until the result
// is taken. Both divider passes run on the shared divider, and both CORDIC
// passes on the shared CORDIC.
// A stalled receiver holds the result in the output register.
// Reset clears the angle to zero and restores register defaults.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module epitrochoid_point_generator #(
  parameter int unsigned CORDIC_STEPS    = 20,
  parameter int unsigned ANGLE_FRAC_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // advance
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // centre_x, centre_y, pen_x, pen_y
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int unsigned AB = epg_pkg::AccBits;
  localparam int unsigned RB = epg_pkg::RadBits;
  localparam int unsigned FB = ANGLE_FRAC_BITS;

  logic [RB-1:0] r1_q, r2_q, r3_q;
  logic [epg_pkg::SpdBits-1:0] spd_q;
  logic [AB-1:0] ang_q;
  logic [FB-1:0] pen_ph_q, pen_ph_d;
  epg_pkg::state_e st_q, st_d;
  logic signed [20:0] cx_q, cy_q;
  logic [79:0] out_q;

  // Configuration registers
  logic [1:0] ridx;
  assign ridx   = paddr[3:2];
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_q <= RB'(5632); r2_q <= RB'(2560); r3_q <= RB'(3584); spd_q <= 24'd134218;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        epg_pkg::RegFixed:   r1_q  <= pwdata[RB-1:0];
        epg_pkg::RegRolling: r2_q  <= pwdata[RB-1:0];
        epg_pkg::RegPen:     r3_q  <= pwdata[RB-1:0];
        default:             spd_q <= pwdata[23:0];
      endcase
    end
  end
  always_comb begin
    unique case (ridx)
      epg_pkg::RegFixed:   prdata = 32'(r1_q);
      epg_pkg::RegRolling: prdata = 32'(r2_q);
      epg_pkg::RegPen:     prdata = 32'(r3_q);
      default:             prdata = 32'(spd_q);
    endcase
  end

  // Shared divider: first angle / r2, then (ra * r1) / r2 on the same unit.
  // Pen phase = a + qa*r1 + floor(ra*r1/r2), kept to one turn.
  logic div_start, div_done;
  logic [AB-1:0] qa, div_num;
  logic [RB-1:0] ra;
  logic [AB-1:0] prod_q;
  logic [2*RB-1:0] prod_w;
  assign div_num = (st_q == epg_pkg::ST_EXTRA) ? prod_q : ang_q;
  assign prod_w  = {{RB{1'b0}}, ra} * {{RB{1'b0}}, r1_q};
  epg_divider #(.NumW(AB), .DenW(RB)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(r2_q),
    .done_o(div_done), .quo_o(qa), .rem_o(ra));

  epg_pkg::cord_ctl_t cctl;
  logic cdone;
  logic [ANGLE_FRAC_BITS-1:0] cphase;
  logic [RB:0] crad;
  logic signed [20:0] cxo, cyo;
  epg_cordic #(.Steps(CORDIC_STEPS), .FracBits(ANGLE_FRAC_BITS)) u_cordic (
    .clk_i, .rst_ni, .ctl_i(cctl), .phase_i(cphase), .radius_i(crad),
    .done_o(cdone), .x_o(cxo), .y_o(cyo));

  logic acc_in, busy_q, busy_d;
  logic out_full_q;
  assign acc_in = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (st_q == epg_pkg::ST_IDLE) && !out_full_q;

  // Next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      epg_pkg::ST_IDLE:     if (acc_in) st_d = (r2_q == '0) ? epg_pkg::ST_CEN_INIT
                                                           : epg_pkg::ST_DIV;
      epg_pkg::ST_DIV:      if (div_done) st_d = epg_pkg::ST_EXTRA;
      epg_pkg::ST_EXTRA:    if (div_done) st_d = epg_pkg::ST_CEN_INIT;
      epg_pkg::ST_CEN_INIT: st_d = epg_pkg::ST_CEN_RUN;
      epg_pkg::ST_CEN_RUN:  if (cdone) st_d = epg_pkg::ST_PEN_INIT;
      epg_pkg::ST_PEN_INIT: st_d = epg_pkg::ST_PEN_RUN;
      epg_pkg::ST_PEN_RUN:  if (cdone) st_d = epg_pkg::ST_OUT;
      default:              st_d = epg_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  logic div_go_q, fr_go_q;
  always_comb begin
    cctl.start = (st_q == epg_pkg::ST_CEN_INIT) || (st_q == epg_pkg::ST_PEN_INIT);
    busy_d     = busy_q;
    if (cctl.start) busy_d = 1'b1;
    else if (cdone) busy_d = 1'b0;
    cctl.busy  = busy_q && !cdone;
    cctl.done  = cdone;
    cphase     = (st_q == epg_pkg::ST_PEN_INIT) ? pen_ph_q
                                                : ang_q[ANGLE_FRAC_BITS-1:0];
    crad       = (st_q == epg_pkg::ST_PEN_INIT) ? {1'b0, r3_q}
                                                : ({1'b0, r1_q} + {1'b0, r2_q});
    div_start  = div_go_q || fr_go_q;
    pen_ph_d   = pen_ph_q;
    if (acc_in && r2_q == '0)
      pen_ph_d = FB'(ang_q + ((s_axis_tdata[0]) ? AB'(spd_q) : '0));
    else if (st_q == epg_pkg::ST_DIV && div_done)
      pen_ph_d = ang_q[FB-1:0] + FB'(qa[FB-1:0] * FB'(r1_q));
    else if (st_q == epg_pkg::ST_EXTRA && div_done)
      pen_ph_d = pen_ph_q + qa[FB-1:0];
  end

  // Saturated result packing
  function automatic logic [19:0] sat(input logic signed [21:0] v, input logic [19:0] lim);
    logic signed [21:0] l;
    begin
      l = $signed({2'b00, lim});
      if (v > l) return lim;
      if (v < -l) return 20'(-l);
      return v[19:0];
    end
  endfunction
  logic [19:0] scx, scy, spx, spy;
  assign scx = sat(22'(cx_q), 20'd262143);
  assign scy = sat(22'(cy_q), 20'd262143);
  assign spx = sat(22'(cx_q) + 22'(cxo), 20'd524287);
  assign spy = sat(22'(cy_q) + 22'(cyo), 20'd524287);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= epg_pkg::ST_IDLE; ang_q <= '0; busy_q <= 1'b0;
      div_go_q <= 1'b0; fr_go_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      busy_q   <= busy_d;
      div_go_q <= acc_in && (r2_q != '0);
      fr_go_q  <= (st_q == epg_pkg::ST_DIV) && div_done;
      if (acc_in && s_axis_tdata[0]) ang_q <= ang_q + AB'(spd_q);
    end
  end

  always_ff @(posedge clk_i) begin
    pen_ph_q <= pen_ph_d;
    if (st_q == epg_pkg::ST_DIV && div_done) prod_q <= AB'(prod_w);
    if (st_q == epg_pkg::ST_CEN_RUN && cdone) begin cx_q <= cxo; cy_q <= cyo; end
    if (st_q == epg_pkg::ST_OUT) out_q <= {2'b00, spy, spx, scy[18:0], scx[18:0]};
  end

  // Result register: loaded in the output state, held until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_full_q <= 1'b0;
    else if (st_q == epg_pkg::ST_OUT) out_full_q <= 1'b1;
    else if (m_axis_tvalid && m_axis_tready) out_full_q <= 1'b0;
  end
  assign m_axis_tvalid = out_full_q;
  assign m_axis_tdata  = out_q;
endmodule

FILE: hdl/epg_checker.sv
// ---------------------------------------------------------------------------
// epg_checker
// Port-level checks of the epitrochoid point generator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "epitrochoid_point_generator_macros.svh"
module epg_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [79:0] m_axis_tdata
);
  `EPG_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "accepted twice")
  `EPG_ASSERT_IMP(a_no_accept_while_full, m_axis_tvalid, !s_axis_tready, "input taken while result waits")
  `EPG_ASSERT_NXT(a_hold_result, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed under stall")
endmodule

bind epitrochoid_point_generator epg_checker u_chk (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata);

FILE: tb/testbench.sv
// ---------------------------------------------------------------------------
// Epitrochoid point generator testbench
// Drives tick words with bursty gaps, stalls the result side, rewrites the
// radius and speed registers between phases and checks every result word
// against a bit-exact CORDIC predictor held in the bench.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned Steps   = 20;
  localparam int unsigned Frac    = 24;
  localparam int unsigned SettleCycles = 200;

  typedef struct packed {
    logic signed [19:0] pen_y;
    logic signed [19:0] pen_x;
    logic signed [18:0] centre_y;
    logic signed [18:0] centre_x;
  } point_t;

  typedef struct {
    logic   advance;
    logic   known;
    point_t pt;
  } tick_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // bit 0: advance, rest zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;        // centre_x, centre_y, pen_x, pen_y
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  epitrochoid_point_generator dut (.*);

  always #4 clk_i = ~clk_i;

  // predictor state
  logic [16:0] fixed_r = 17'd5632, rolling_r = 17'd2560, pen_r = 17'd3584;
  logic [23:0] step_speed = 24'd134218;
  logic [47:0] angle_acc = '0;
  point_t      points_pending[$];
  int          errors = 0;
  bit          stall_off = 1'b0;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic [31:0] arc_step(int i);
    logic [31:0] t [30] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001};
    return t[i];
  endfunction

  // radius times (cos, sin) of a phase, rounded to 1/1024 units
  task automatic rotate_radius(input longint unsigned radius, input logic [47:0] phase,
                               output longint ox, output longint oy);
    longint unsigned one, p, q, r;
    longint zr, x, y, dx, dy, t;
    one = 64'd1 << Frac;
    p = phase & (one - 1);
    q = ((p + (one >> 3)) >> (Frac - 2)) & 3;
    r = (p - q * (one >> 2)) & (one - 1);
    zr = (r >= (one >> 1)) ? longint'(r) - longint'(one) : longint'(r);
    zr = zr * (64'sd1 <<< (32 - Frac));
    x = longint'((radius * 64'h9B74EDA8) >> 20);
    y = 0;
    for (int i = 0; i < Steps; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (zr >= 0) begin
        x -= dx; y += dy; zr -= longint'(arc_step(i));
      end else begin
        x += dx; y -= dy; zr += longint'(arc_step(i));
      end
    end
    case (q)
      1: begin t = x; x = -y; y = t; end
      2: begin x = -x; y = -y; end
      3: begin t = x; x = y; y = -t; end
      default: ;
    endcase
    ox = floor_shr(x + 2048, 12);
    oy = floor_shr(y + 2048, 12);
  endtask

  function automatic longint sat(longint v, longint lim);
    return v > lim ? lim : (v < -lim ? -lim : v);
  endfunction

  // advance the angle and form the expected point
  task automatic predict_point(input logic adv, output point_t pt);
    longint cx, cy, ox, oy;
    longint unsigned a, qa, ra, pen_phase;
    if (adv) angle_acc = angle_acc + step_speed;
    a = angle_acc;
    rotate_radius(64'(fixed_r) + 64'(rolling_r), angle_acc, cx, cy);
    if (rolling_r == 0) begin
      pen_phase = a;
    end else begin
      qa = a / rolling_r;
      ra = a % rolling_r;
      pen_phase = a + qa * fixed_r + (ra * fixed_r) / rolling_r;
    end
    rotate_radius(pen_r, pen_phase[47:0], ox, oy);
    pt.centre_x = 19'(sat(cx, 262143));
    pt.centre_y = 19'(sat(cy, 262143));
    pt.pen_x = 20'(sat(cx + ox, 524287));
    pt.pen_y = 20'(sat(cy + oy, 524287));
  endtask

  // result side: check each accepted word against the oldest expectation
  always @(posedge clk_i) begin
    point_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[77:0];
      if (points_pending.size() == 0) begin
        $display("%0t: unexpected word %h", $realtime, got);
        errors++;
      end else begin
        want = points_pending.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected cx=%0d cy=%0d px=%0d py=%0d",
                   $realtime, want.centre_x, want.centre_y, want.pen_x, want.pen_y);
          $display("%0t:          actual   cx=%0d cy=%0d px=%0d py=%0d",
                   $realtime, got.centre_x, got.centre_y, got.pen_x, got.pen_y);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern: phases of always-ready and random stalls
  always @(posedge clk_i) begin
    int phase_cnt;
    phase_cnt = int'(($time / 8) % 3000);
    if (stall_off || phase_cnt < 600) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
    case (idx)
      epg_pkg::RegFixed:   fixed_r = val[16:0];
      epg_pkg::RegRolling: rolling_r = val[16:0];
      epg_pkg::RegPen:     pen_r = val[16:0];
      default:             step_speed = val[23:0];
    endcase
  endtask

  // drop the input and wait until every expected word has come
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (points_pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // send one tick word; a typed expectation is checked against the predictor
  task automatic send_tick(input logic adv, input logic known, input point_t typed);
    point_t pt;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, adv};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_point(adv, pt);
    if (known && pt !== typed) begin
      $display("%0t: predictor disagrees with typed row %h vs %h", $realtime, pt, typed);
      errors++;
    end
    points_pending.push_back(pt);
  endtask

  task automatic burst_ticks(input int n, input int adv_pct);
    int burst;
    burst = 0;
    for (int k = 0; k < n; k++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        if ($urandom_range(0, 2) == 0) begin
          s_axis_tvalid <= 1'b0;
          repeat ($urandom_range(1, 150)) @(posedge clk_i);
        end
      end
      burst--;
      send_tick($urandom_range(0, 99) < adv_pct, 1'b0, '0);
    end
  endtask

  tick_row_t directed[$];

  initial begin
    point_t    zero_pt;
    logic [31:0] cfg [4];
    zero_pt = '0;
    // after reset at angle zero: centre on +x, pen at r1+r2+r3 on +x
    zero_pt.centre_x = 19'sd8192;
    zero_pt.pen_x = 20'sd11776;
    directed.push_back('{1'b0, 1'b1, zero_pt});
    directed.push_back('{1'b0, 1'b1, zero_pt});
    for (int k = 0; k < 8; k++) directed.push_back('{1'b1, 1'b0, '0});
    directed.push_back('{1'b0, 1'b0, '0});

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    foreach (directed[k]) send_tick(directed[k].advance, directed[k].known, directed[k].pt);
    drain_results();

    // zero rolling radius, large speed, extreme radii
    reg_write(epg_pkg::RegRolling, 32'hFFFE_0000);
    reg_write(epg_pkg::RegSpeed, 32'hFF00_0000 | 24'd13350944);
    for (int k = 0; k < 6; k++) send_tick(1'b1, 1'b0, '0);
    drain_results();
    reg_write(epg_pkg::RegFixed, 32'd102400);
    reg_write(epg_pkg::RegRolling, 32'd102400);
    reg_write(epg_pkg::RegPen, 32'd102400);
    reg_write(epg_pkg::RegSpeed, 32'hFFFFFFFF);
    for (int k = 0; k < 6; k++) send_tick(1'b1, 1'b0, '0);
    drain_results();
    reg_write(epg_pkg::RegFixed, 32'd0);
    reg_write(epg_pkg::RegPen, 32'd0);
    reg_write(epg_pkg::RegRolling, 32'd1);
    for (int k = 0; k < 4; k++) send_tick(1'b1, 1'b0, '0);
    drain_results();

    // random phases with fresh settings
    for (int ph = 0; ph < 16; ph++) begin
      cfg[0] = (ph % 4 == 0) ? 32'd102400 : $urandom_range(0, 102400);
      cfg[1] = (ph % 5 == 0) ? 32'd0 : $urandom_range(1, 102400) | ($urandom & 32'hFFFE0000);
      cfg[2] = (ph % 3 == 0) ? 32'd0 : $urandom_range(0, 102400);
      cfg[3] = (ph % 6 == 1) ? $urandom : $urandom_range(0, 13350944);
      foreach (cfg[i]) reg_write(i[1:0], cfg[i]);
      stall_off = (ph % 4 == 3);
      burst_ticks(100, (ph % 7 == 2) ? 20 : 85);
      drain_results();
    end

    repeat (SettleCycles) @(posedge clk_i);
    if (errors == 0) $display("epitrochoid_point_generator test passed");
    else $display("epitrochoid_point_generator test failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("epitrochoid_point_generator test failed");
    $finish;
  end
endmodule
